// File: sv/yqb_pkg.sv
// Package: shared types and constants of the YUV quad to BGR converter.
`default_nettype none

package yqb_pkg;

	// Field widths and pixel counts
	localparam int unsigned PIX_W    = 8;
	localparam int unsigned NUM_PIX  = 4;
	localparam int unsigned NUM_CH   = 3;
	localparam int unsigned NUM_OUT  = NUM_PIX * NUM_CH;
	localparam int unsigned DIFF_W   = PIX_W + 1;
	localparam int unsigned PROD_W   = 18;
	localparam int unsigned SUM_W    = 20;
	localparam int unsigned FRAC_W   = 8;

	// Channel positions within one pixel
	localparam int unsigned CH_BLUE  = 0;
	localparam int unsigned CH_GREEN = 1;
	localparam int unsigned CH_RED   = 2;

	// BT.601 offsets and coefficients
	localparam logic signed [DIFF_W-1:0] LUMA_OFFSET   = 9'sd16;
	localparam logic signed [DIFF_W-1:0] CHROMA_OFFSET = 9'sd128;
	localparam logic signed [10:0]       COEF_Y        = 11'sd298;
	localparam logic signed [10:0]       COEF_RV       = 11'sd409;
	localparam logic signed [10:0]       COEF_GV       = -11'sd208;
	localparam logic signed [10:0]       COEF_GU       = -11'sd100;
	localparam logic signed [10:0]       COEF_BU       = 11'sd517;

	localparam logic [PIX_W-1:0] PIX_MAX = '1;

	typedef logic [PIX_W-1:0]         pix_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0]  sum_t;

	// One accepted input item
	typedef struct packed {
		pix_t [NUM_PIX-1:0] luma;
		pix_t               u;
		pix_t               v;
	} yuv_t;

	// Products held after the multiply stage
	typedef struct packed {
		prod_t [NUM_PIX-1:0] yterm;
		prod_t               blue_u;
		prod_t               green_v;
		prod_t               green_u;
		prod_t               red_v;
	} prod_set_t;

	// Unclamped channel sums, index pixel*NUM_CH + channel
	typedef struct packed {
		sum_t [NUM_OUT-1:0] ch;
	} sum_set_t;

	// Clamped output channels, same indexing
	typedef struct packed {
		pix_t [NUM_OUT-1:0] ch;
	} bgr_t;

endpackage

`default_nettype wire

// File: sv/yqb_yuv_if.sv
// Interface: input channel carrying one 2x2 luma group and its chroma pair.
`default_nettype none

interface yqb_yuv_if;
	logic       valid;
	logic       ready;
	logic [7:0] luma_top_left;
	logic [7:0] luma_top_right;
	logic [7:0] luma_bottom_left;
	logic [7:0] luma_bottom_right;
	logic [7:0] chroma_u;
	logic [7:0] chroma_v;

	modport source (
		output valid, luma_top_left, luma_top_right, luma_bottom_left,
		output luma_bottom_right, chroma_u, chroma_v,
		input  ready
	);

	modport sink (
		input  valid, luma_top_left, luma_top_right, luma_bottom_left,
		input  luma_bottom_right, chroma_u, chroma_v,
		output ready
	);
endinterface

`default_nettype wire

// File: sv/yqb_bgr_if.sv
// Interface: output channel carrying four BGR pixels.
`default_nettype none

interface yqb_bgr_if;
	logic       valid;
	logic       ready;
	logic [7:0] top_left_blue;
	logic [7:0] top_left_green;
	logic [7:0] top_left_red;
	logic [7:0] top_right_blue;
	logic [7:0] top_right_green;
	logic [7:0] top_right_red;
	logic [7:0] bottom_left_blue;
	logic [7:0] bottom_left_green;
	logic [7:0] bottom_left_red;
	logic [7:0] bottom_right_blue;
	logic [7:0] bottom_right_green;
	logic [7:0] bottom_right_red;

	modport source (
		output valid,
		output top_left_blue, top_left_green, top_left_red,
		output top_right_blue, top_right_green, top_right_red,
		output bottom_left_blue, bottom_left_green, bottom_left_red,
		output bottom_right_blue, bottom_right_green, bottom_right_red,
		input  ready
	);

	modport sink (
		input  valid,
		input  top_left_blue, top_left_green, top_left_red,
		input  top_right_blue, top_right_green, top_right_red,
		input  bottom_left_blue, bottom_left_green, bottom_left_red,
		input  bottom_right_blue, bottom_right_green, bottom_right_red,
		output ready
	);
endinterface

`default_nettype wire

// File: sv/yqb_mult.sv
// Module: first pipeline stage, removes offsets and forms all coefficient products.
`default_nettype none

module yqb_mult
	import yqb_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      up_valid,
	output      logic      up_ready,
	input  wire yuv_t      up_data,
	output      logic      dn_valid,
	input  wire logic      dn_ready,
	output      prod_set_t dn_data
);

	logic                     valid_s1;
	prod_set_t                prod_s1;
	prod_set_t                prod_d;
	logic signed [DIFF_W-1:0] u_diff;
	logic signed [DIFF_W-1:0] v_diff;
	logic signed [DIFF_W-1:0] y_diff [NUM_PIX];

	// Take a new transaction when empty or when the next stage drains this one
	assign up_ready = !valid_s1 || dn_ready;

	// Centre the samples and multiply by the fixed coefficients at full product width
	always_comb begin
		u_diff = $signed({1'b0, up_data.u}) - CHROMA_OFFSET;
		v_diff = $signed({1'b0, up_data.v}) - CHROMA_OFFSET;
		for (int p = 0; p < NUM_PIX; p++) begin
			y_diff[p]        = $signed({1'b0, up_data.luma[p]}) - LUMA_OFFSET;
			prod_d.yterm[p]  = PROD_W'(y_diff[p]) * PROD_W'(COEF_Y);
		end
		prod_d.blue_u  = PROD_W'(u_diff) * PROD_W'(COEF_BU);
		prod_d.green_v = PROD_W'(v_diff) * PROD_W'(COEF_GV);
		prod_d.green_u = PROD_W'(u_diff) * PROD_W'(COEF_GU);
		prod_d.red_v   = PROD_W'(v_diff) * PROD_W'(COEF_RV);
	end

	// Advance the valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	// Hold products until the next stage takes them
	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			prod_s1 <= prod_d;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_data  = prod_s1;

endmodule

`default_nettype wire

// File: sv/yqb_sum.sv
// Module: second pipeline stage, adds luma and chroma products per channel.
`default_nettype none

module yqb_sum
	import yqb_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      up_valid,
	output      logic      up_ready,
	input  wire prod_set_t up_data,
	output      logic      dn_valid,
	input  wire logic      dn_ready,
	output      sum_set_t  dn_data
);

	logic     valid_s2;
	sum_set_t sum_s2;
	sum_set_t sum_d;

	assign up_ready = !valid_s2 || dn_ready;

	// Form the three channel sums of every pixel
	always_comb begin
		for (int p = 0; p < NUM_PIX; p++) begin
			sum_d.ch[p*NUM_CH + CH_BLUE]  = SUM_W'(up_data.yterm[p]) + SUM_W'(up_data.blue_u);
			sum_d.ch[p*NUM_CH + CH_GREEN] = SUM_W'(up_data.yterm[p])
				+ SUM_W'(up_data.green_v) + SUM_W'(up_data.green_u);
			sum_d.ch[p*NUM_CH + CH_RED]   = SUM_W'(up_data.yterm[p]) + SUM_W'(up_data.red_v);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (up_ready) begin
			valid_s2 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			sum_s2 <= sum_d;
		end
	end

	assign dn_valid = valid_s2;
	assign dn_data  = sum_s2;

endmodule

`default_nettype wire

// File: sv/yqb_clamp.sv
// Module: third pipeline stage, scales sums down and clamps them to eight bits.
`default_nettype none

module yqb_clamp
	import yqb_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     up_valid,
	output      logic     up_ready,
	input  wire sum_set_t up_data,
	output      logic     dn_valid,
	input  wire logic     dn_ready,
	output      bgr_t     dn_data
);

	logic valid_s3;
	bgr_t bgr_s3;
	bgr_t bgr_d;

	assign up_ready = !valid_s3 || dn_ready;

	// Drop negative sums to zero, saturate anything at or above 256 after the shift
	always_comb begin
		for (int k = 0; k < NUM_OUT; k++) begin
			if (up_data.ch[k][SUM_W-1]) begin
				bgr_d.ch[k] = '0;
			end else if (|up_data.ch[k][SUM_W-2:FRAC_W+PIX_W]) begin
				bgr_d.ch[k] = PIX_MAX;
			end else begin
				bgr_d.ch[k] = up_data.ch[k][FRAC_W+PIX_W-1:FRAC_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (up_ready) begin
			valid_s3 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			bgr_s3 <= bgr_d;
		end
	end

	assign dn_valid = valid_s3;
	assign dn_data  = bgr_s3;

endmodule

`default_nettype wire

// File: sv/yuv_quad_to_bgr_converter.sv
// Top level: YUV 2x2 group with NV12 chroma pair to four BGR pixels, BT.601.
//
// Usage:
//   yuv_in  takes one transaction per 2x2 luma group plus its shared U/V pair.
//   bgr_out presents the four converted pixels, blue/green/red each, clamped
//   to 0..255 with truncation (no rounding term).
//   An accepted input transaction reaches bgr_out.valid through three stages:
//   stage one removes offsets and multiplies, stage two adds the products,
//   stage three shifts and clamps into the output register.
//   Throughput is one transaction per cycle while bgr_out.ready is high.
//   Each stage loads whenever it is empty or its successor takes its contents,
//   so yuv_in.ready is low only when all three stages hold data and the
//   receiver stalls; while bgr_out.ready is low the result is held unchanged
//   and nothing is lost or repeated.
//   Reset (arst_n low) empties all stages at once; data registers are not
//   cleared. The block has no configuration and no state beyond the pipeline.
`default_nettype none

module yuv_quad_to_bgr_converter
	import yqb_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	yqb_yuv_if.sink  yuv_in,
	yqb_bgr_if.source bgr_out
);

	yuv_t      in_data;
	prod_set_t prod_data;
	sum_set_t  sum_data;
	bgr_t      bgr_data;
	logic      s1_valid;
	logic      s1_ready;
	logic      s2_valid;
	logic      s2_ready;

	// Gather the input fields, pixel index 0..3 = TL, TR, BL, BR
	assign in_data.luma[0] = yuv_in.luma_top_left;
	assign in_data.luma[1] = yuv_in.luma_top_right;
	assign in_data.luma[2] = yuv_in.luma_bottom_left;
	assign in_data.luma[3] = yuv_in.luma_bottom_right;
	assign in_data.u       = yuv_in.chroma_u;
	assign in_data.v       = yuv_in.chroma_v;

	yqb_mult u_mult (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (yuv_in.valid),
		.up_ready (yuv_in.ready),
		.up_data  (in_data),
		.dn_valid (s1_valid),
		.dn_ready (s1_ready),
		.dn_data  (prod_data)
	);

	yqb_sum u_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (s1_valid),
		.up_ready (s1_ready),
		.up_data  (prod_data),
		.dn_valid (s2_valid),
		.dn_ready (s2_ready),
		.dn_data  (sum_data)
	);

	yqb_clamp u_clamp (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (s2_valid),
		.up_ready (s2_ready),
		.up_data  (sum_data),
		.dn_valid (bgr_out.valid),
		.dn_ready (bgr_out.ready),
		.dn_data  (bgr_data)
	);

	// Spread the result onto the output fields
	assign bgr_out.top_left_blue      = bgr_data.ch[0*NUM_CH + CH_BLUE];
	assign bgr_out.top_left_green     = bgr_data.ch[0*NUM_CH + CH_GREEN];
	assign bgr_out.top_left_red       = bgr_data.ch[0*NUM_CH + CH_RED];
	assign bgr_out.top_right_blue     = bgr_data.ch[1*NUM_CH + CH_BLUE];
	assign bgr_out.top_right_green    = bgr_data.ch[1*NUM_CH + CH_GREEN];
	assign bgr_out.top_right_red      = bgr_data.ch[1*NUM_CH + CH_RED];
	assign bgr_out.bottom_left_blue   = bgr_data.ch[2*NUM_CH + CH_BLUE];
	assign bgr_out.bottom_left_green  = bgr_data.ch[2*NUM_CH + CH_GREEN];
	assign bgr_out.bottom_left_red    = bgr_data.ch[2*NUM_CH + CH_RED];
	assign bgr_out.bottom_right_blue  = bgr_data.ch[3*NUM_CH + CH_BLUE];
	assign bgr_out.bottom_right_green = bgr_data.ch[3*NUM_CH + CH_GREEN];
	assign bgr_out.bottom_right_red   = bgr_data.ch[3*NUM_CH + CH_RED];

`ifndef NO_ASSERTIONS
	// A free receiver lets every stage advance, so input must be ready
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		bgr_out.ready |-> yuv_in.ready)
		else $error("input stalled while receiver was ready");

	// Back-pressure on input only when the whole pipeline is full
	a_full_only: assert property (@(posedge clk) disable iff (!arst_n)
		!yuv_in.ready |-> (s1_valid && s2_valid && bgr_out.valid))
		else $error("input stalled with an empty stage");

	// Without stalls an accepted transaction reaches bgr_out.valid via all stages
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(yuv_in.valid && yuv_in.ready) ##1 bgr_out.ready ##1 bgr_out.ready
		|=> bgr_out.valid)
		else $error("result missing after pipeline latency");
`endif

endmodule

`default_nettype wire

// File: test/yuv_quad_to_bgr_converter_tb.sv
// Testbench: YUV quad to BGR converter checked against a BT.601 pixel predictor.

module yuv_quad_to_bgr_converter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import yqb_pkg::*;

	localparam realtime CLK_PERIOD      = 12ns;
	localparam int      RESET_CYCLES    = 4;
	localparam int      RANDOM_PER_PHASE = 500;
	localparam int      HOLD_OFF_CYCLES = 80;
	localparam int      DRAIN_CYCLES    = 10;
	localparam int      WATCHDOG_LIMIT  = 1000;
	localparam int      MAX_REPORTS     = 10;

	// Pixel positions within one 2x2 group
	localparam int PIX_TOP_LEFT     = 0;
	localparam int PIX_TOP_RIGHT    = 1;
	localparam int PIX_BOTTOM_LEFT  = 2;
	localparam int PIX_BOTTOM_RIGHT = 3;

	// BT.601 integer conversion, 8 fractional bits
	localparam int LUMA_BIAS   = 16;
	localparam int CHROMA_BIAS = 128;
	localparam int GAIN_Y      = 298;
	localparam int GAIN_RED_V  = 409;
	localparam int GAIN_GRN_V  = -208;
	localparam int GAIN_GRN_U  = -100;
	localparam int GAIN_BLUE_U = 517;
	localparam int CH_LIMIT    = 255;

	string PIXEL_NAME [NUM_PIX] = '{"top_left", "top_right", "bottom_left", "bottom_right"};
	string CHANNEL_NAME [NUM_CH] = '{"blue", "green", "red"};

	logic clk;
	logic arst_n;

	yqb_yuv_if yuv_ch ();
	yqb_bgr_if bgr_ch ();

	yuv_quad_to_bgr_converter u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.yuv_in  (yuv_ch),
		.bgr_out (bgr_ch)
	);

	bgr_t pending_bgr_q [$];
	int   mismatch_count  = 0;
	int   send_idle_pct   = 0;
	int   sink_stall_pct  = 0;
	int   hold_off_cycles = 0;
	int   quiet_cycles    = 0;

	// Saturate one channel sum to the 8-bit range
	function automatic pix_t clamp_channel_sum(input int sum);
		int scaled;
		if (sum < 0)
			return '0;
		scaled = sum >>> FRAC_W;
		if (scaled > CH_LIMIT)
			return PIX_MAX;
		return pix_t'(scaled);
	endfunction

	// Predict the four BGR pixels of one luma group
	function automatic bgr_t convert_quad(input yuv_t quad);
		bgr_t px;
		int   u;
		int   v;
		int   yterm;
		u = int'(quad.u) - CHROMA_BIAS;
		v = int'(quad.v) - CHROMA_BIAS;
		for (int p = 0; p < NUM_PIX; p++) begin
			yterm = GAIN_Y * (int'(quad.luma[p]) - LUMA_BIAS);
			px.ch[p*NUM_CH + CH_BLUE]  = clamp_channel_sum(yterm + GAIN_BLUE_U * u);
			px.ch[p*NUM_CH + CH_GREEN] = clamp_channel_sum(yterm + GAIN_GRN_V * v
				+ GAIN_GRN_U * u);
			px.ch[p*NUM_CH + CH_RED]   = clamp_channel_sum(yterm + GAIN_RED_V * v);
		end
		return px;
	endfunction

	function automatic yuv_t make_quad(input pix_t tl, input pix_t tr, input pix_t bl,
		input pix_t br, input pix_t u, input pix_t v);
		yuv_t quad;
		quad.luma[PIX_TOP_LEFT]     = tl;
		quad.luma[PIX_TOP_RIGHT]    = tr;
		quad.luma[PIX_BOTTOM_LEFT]  = bl;
		quad.luma[PIX_BOTTOM_RIGHT] = br;
		quad.u = u;
		quad.v = v;
		return quad;
	endfunction

	// Mostly uniform samples, with the offset and clamp boundaries mixed in
	function automatic pix_t random_sample();
		pix_t corners [7] = '{8'd0, 8'd15, 8'd16, 8'd128, 8'd235, 8'd240, 8'd255};
		if ($urandom_range(7) == 0)
			return corners[$urandom_range(6)];
		return pix_t'($urandom_range(255));
	endfunction

	function automatic yuv_t random_quad();
		return make_quad(random_sample(), random_sample(), random_sample(),
			random_sample(), random_sample(), random_sample());
	endfunction

	// Clock
	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Receiver: random stalls, plus a long hold-off when one is requested
	initial begin
		bgr_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_cycles > 0) begin
				bgr_ch.ready = 1'b0;
				hold_off_cycles--;
			end else begin
				bgr_ch.ready = ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	// Compare each accepted result with the oldest prediction
	always @(posedge clk) begin : check_results
		bgr_t got;
		bgr_t want;
		if (arst_n && bgr_ch.valid && bgr_ch.ready) begin
			got.ch[PIX_TOP_LEFT*NUM_CH + CH_BLUE]      = bgr_ch.top_left_blue;
			got.ch[PIX_TOP_LEFT*NUM_CH + CH_GREEN]     = bgr_ch.top_left_green;
			got.ch[PIX_TOP_LEFT*NUM_CH + CH_RED]       = bgr_ch.top_left_red;
			got.ch[PIX_TOP_RIGHT*NUM_CH + CH_BLUE]     = bgr_ch.top_right_blue;
			got.ch[PIX_TOP_RIGHT*NUM_CH + CH_GREEN]    = bgr_ch.top_right_green;
			got.ch[PIX_TOP_RIGHT*NUM_CH + CH_RED]      = bgr_ch.top_right_red;
			got.ch[PIX_BOTTOM_LEFT*NUM_CH + CH_BLUE]   = bgr_ch.bottom_left_blue;
			got.ch[PIX_BOTTOM_LEFT*NUM_CH + CH_GREEN]  = bgr_ch.bottom_left_green;
			got.ch[PIX_BOTTOM_LEFT*NUM_CH + CH_RED]    = bgr_ch.bottom_left_red;
			got.ch[PIX_BOTTOM_RIGHT*NUM_CH + CH_BLUE]  = bgr_ch.bottom_right_blue;
			got.ch[PIX_BOTTOM_RIGHT*NUM_CH + CH_GREEN] = bgr_ch.bottom_right_green;
			got.ch[PIX_BOTTOM_RIGHT*NUM_CH + CH_RED]   = bgr_ch.bottom_right_red;
			if (pending_bgr_q.size() == 0) begin
				if (mismatch_count < MAX_REPORTS)
					$display("%0t: result transaction with nothing pending", $realtime);
				mismatch_count++;
			end else begin
				want = pending_bgr_q.pop_front();
				for (int k = 0; k < NUM_OUT; k++) begin
					if (got.ch[k] !== want.ch[k]) begin
						if (mismatch_count < MAX_REPORTS)
							$display("%0t: %s %s expected %0d got %0d", $realtime,
								PIXEL_NAME[k / NUM_CH], CHANNEL_NAME[k % NUM_CH],
								want.ch[k], got.ch[k]);
						mismatch_count++;
					end
				end
			end
		end
	end

	// Watchdog: end the run if nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (yuv_ch.valid && yuv_ch.ready) || (bgr_ch.valid && bgr_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("yuv_quad_to_bgr_converter: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one group, with random idle cycles first, and record its prediction
	task automatic send_quad(input yuv_t quad);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			yuv_ch.valid = 1'b0;
			@(negedge clk);
		end
		yuv_ch.luma_top_left     = quad.luma[PIX_TOP_LEFT];
		yuv_ch.luma_top_right    = quad.luma[PIX_TOP_RIGHT];
		yuv_ch.luma_bottom_left  = quad.luma[PIX_BOTTOM_LEFT];
		yuv_ch.luma_bottom_right = quad.luma[PIX_BOTTOM_RIGHT];
		yuv_ch.chroma_u          = quad.u;
		yuv_ch.chroma_v          = quad.v;
		yuv_ch.valid             = 1'b1;
		do
			@(posedge clk);
		while (!yuv_ch.ready);
		pending_bgr_q.push_back(convert_quad(quad));
	endtask

	// Drop valid after the last transaction of a burst
	task automatic stop_input();
		@(negedge clk);
		yuv_ch.valid = 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_bgr_q.size() != 0)
			@(posedge clk);
	endtask

	// Extremes of every field, clamp edges and pixel ordering
	task automatic test_corner_quads();
		send_idle_pct  = 0;
		sink_stall_pct = 0;
		send_quad(make_quad(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
		send_quad(make_quad(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
		send_quad(make_quad(8'd16, 8'd16, 8'd16, 8'd16, 8'd128, 8'd128));
		send_quad(make_quad(8'd235, 8'd235, 8'd235, 8'd235, 8'd128, 8'd128));
		send_quad(make_quad(8'd255, 8'd255, 8'd255, 8'd255, 8'd128, 8'd128));
		// luma below black level goes negative and clamps to zero
		send_quad(make_quad(8'd0, 8'd5, 8'd10, 8'd15, 8'd128, 8'd128));
		// chroma extremes drive each channel to both clamps
		send_quad(make_quad(8'd128, 8'd128, 8'd128, 8'd128, 8'd255, 8'd128));
		send_quad(make_quad(8'd128, 8'd128, 8'd128, 8'd128, 8'd0, 8'd128));
		send_quad(make_quad(8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd255));
		send_quad(make_quad(8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd0));
		send_quad(make_quad(8'd128, 8'd128, 8'd128, 8'd128, 8'd255, 8'd255));
		send_quad(make_quad(8'd128, 8'd128, 8'd128, 8'd128, 8'd0, 8'd0));
		send_quad(make_quad(8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0));
		send_quad(make_quad(8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255));
		// luma that differs between pixels to catch swapped positions
		send_quad(make_quad(8'd16, 8'd100, 8'd180, 8'd235, 8'd90, 8'd240));
		send_quad(make_quad(8'd1, 8'd2, 8'd4, 8'd8, 8'd16, 8'd32));
		send_quad(make_quad(8'd64, 8'd128, 8'd170, 8'd85, 8'd127, 8'd129));
		send_quad(make_quad(8'hAA, 8'h55, 8'hAA, 8'h55, 8'h55, 8'hAA));
		send_quad(make_quad(8'h55, 8'hAA, 8'h55, 8'hAA, 8'hAA, 8'h55));
		send_quad(make_quad(8'd17, 8'd15, 8'd240, 8'd254, 8'd1, 8'd254));
		stop_input();
	endtask

	// Random groups under one idling pattern
	task automatic test_random_quads(input int count, input int idle_pct, input int stall_pct);
		send_idle_pct  = idle_pct;
		sink_stall_pct = stall_pct;
		repeat (count)
			send_quad(random_quad());
		stop_input();
	endtask

	// Hold the receiver off while the sender keeps offering, so the input stalls
	task automatic test_output_backpressure();
		send_idle_pct   = 0;
		sink_stall_pct  = 0;
		hold_off_cycles = HOLD_OFF_CYCLES;
		repeat (40)
			send_quad(random_quad());
		stop_input();
	endtask

	// Pause the sender until every pending result has come back
	task automatic test_pause_until_drained();
		send_idle_pct  = 24;
		sink_stall_pct = 24;
		repeat (5) begin
			repeat (8)
				send_quad(random_quad());
			stop_input();
			wait_drained();
		end
	endtask

	initial begin
		arst_n                   = 1'b0;
		yuv_ch.valid             = 1'b0;
		yuv_ch.luma_top_left     = '0;
		yuv_ch.luma_top_right    = '0;
		yuv_ch.luma_bottom_left  = '0;
		yuv_ch.luma_bottom_right = '0;
		yuv_ch.chroma_u          = '0;
		yuv_ch.chroma_v          = '0;
		repeat (RESET_CYCLES)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_corner_quads();
		test_random_quads(RANDOM_PER_PHASE, 0, 0);
		test_random_quads(RANDOM_PER_PHASE, 68, 0);
		test_random_quads(RANDOM_PER_PHASE, 0, 68);
		test_random_quads(RANDOM_PER_PHASE, 24, 24);
		test_output_backpressure();
		test_pause_until_drained();

		// Let stray results show up after the last expected one
		wait_drained();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (mismatch_count == 0 && pending_bgr_q.size() == 0)
			$display("yuv_quad_to_bgr_converter: match");
		else
			$display("yuv_quad_to_bgr_converter: mismatch");
		$finish;
	end

endmodule

// File: files.f
sv/yqb_pkg.sv
sv/yqb_yuv_if.sv
sv/yqb_bgr_if.sv
sv/yqb_mult.sv
sv/yqb_sum.sv
sv/yqb_clamp.sv
sv/yuv_quad_to_bgr_converter.sv
test/yuv_quad_to_bgr_converter_tb.sv
